// ===== rtl/core/dspc_pkg.sv =====
// dspc_pkg: shared constants for the dual sensor plausibility check
// register widths, reset values, register indexes and sequencer sizes
// no dependencies
package dspc_pkg;

  localparam int ADC_BITS_DEFAULT = 12;

  localparam int GAIN_W     = 20;
  localparam int OFFSET_W   = 28;
  localparam int TOL_W      = 7;
  localparam int LIMIT_W    = 16;
  localparam int CFG_DATA_W = 28;
  localparam int CFG_IDX_W  = 2;

  // the window multipliers 100-t and 100+t fit in one signed or unsigned byte
  localparam int WIN_STEPS = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd3;

  localparam logic [GAIN_W-1:0]          GAIN_RESET   = 20'd122939;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 28'sd12584878;
  localparam logic [TOL_W-1:0]           TOL_RESET    = 7'd10;
  localparam logic [LIMIT_W-1:0]         LIMIT_RESET  = 16'd10;

  localparam logic [LIMIT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]         PERCENT_FULL = 8'd100;

endpackage

// ===== rtl/core/dual_sensor_plausibility_check_unit.sv =====
// dual_sensor_plausibility_check_unit: top level of the pedal sensor plausibility check
// bit-serial predictor and window test followed by the debounce state
// depends on dspc_pkg
// usage
//   s_tdata carries one pair of pedal sensor samples; m_tdata returns the
//   debounced verdict and the plausibility state, one word out per word in.
//   the cfg port writes gain, offset, tolerance and fault limit; the user must
//   write them only while idle, since the block itself does not enforce it.
// timing
//   an accepted word runs through a shift-add multiplier for the prediction
//   (one low-gain sample bit per cycle), then through two shift-add
//   accumulators for the window bounds (one multiplier bit per cycle), then
//   updates the debounce state in S_FIN. the result becomes valid in the
//   same cycle as the input reopens; a new word is taken only while idle.
// reset
//   registers return to their defaults, state is plausible, counts are zero.
// stall
//   a pending result sits in the output register while the next word is
//   accepted and computed; that word waits in its last cycle until the
//   output register frees up.
module dual_sensor_plausibility_check_unit #(
  parameter int ADC_BITS = dspc_pkg::ADC_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // reading_high, reading_low
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]        s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // agrees, plausible
  output logic [7:0]                             m_tdata,
  input  logic                                   cfg_we,
  input  logic [dspc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dspc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import dspc_pkg::*;

  localparam int PROD_W = GAIN_W + ADC_BITS;
  localparam int PRED_W = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 2;
  localparam int ACC_W  = PRED_W + 9;
  localparam int X100_W = ADC_BITS + 7;
  localparam int CNT_W  = ($clog2(ADC_BITS) > 3) ? $clog2(ADC_BITS) : 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WIN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;

  logic [GAIN_W-1:0]          gain;
  logic signed [OFFSET_W-1:0] offset;
  logic [TOL_W-1:0]           tolerance;
  logic [LIMIT_W-1:0]         limit;

  logic [CNT_W-1:0]           cnt;
  logic [ADC_BITS-1:0]        low_sr;
  logic [7:0]                 mlo_sr;
  logic [7:0]                 mhi_sr;
  logic signed [ACC_W-1:0]    mcand;
  logic signed [PRED_W-1:0]   pred;
  logic signed [PRED_W-1:0]   pred_next;
  logic signed [ACC_W-1:0]    acc_lo;
  logic signed [ACC_W-1:0]    acc_hi;

  logic                       plausible_flag;
  logic [LIMIT_W-1:0]         disagree_count;
  logic [LIMIT_W-1:0]         agree_count;

  logic                       agrees_out;
  logic                       plausible_out;

  logic [ADC_BITS-1:0]        reading_high;
  logic [ADC_BITS-1:0]        reading_low;
  logic [X100_W-1:0]          high_x100;
  logic signed [ACC_W-1:0]    meas;

  logic                       in_accept;
  logic                       commit;
  logic                       in_window;
  logic [LIMIT_W-1:0]         dc_inc;
  logic [LIMIT_W-1:0]         ac_inc;
  logic [LIMIT_W-1:0]         disagree_count_next;
  logic [LIMIT_W-1:0]         agree_count_next;
  logic                       plausible_flag_next;
  logic                       agrees_next;

  assign reading_high = s_tdata[ADC_BITS-1:0];
  assign reading_low  = s_tdata[2*ADC_BITS-1:ADC_BITS];
  assign high_x100 = (X100_W'(reading_high) << 6) + (X100_W'(reading_high) << 5)
                   + (X100_W'(reading_high) << 2);
  assign meas = signed'(ACC_W'(high_x100) << 16);

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign commit    = (state == S_FIN) && (!m_tvalid || m_tready);

  assign pred_next = low_sr[0] ? pred + PRED_W'(mcand) : pred;

  assign in_window = !pred[PRED_W-1] && !acc_lo[ACC_W-1] && !acc_hi[ACC_W-1];
  assign dc_inc = (disagree_count == COUNT_MAX) ? disagree_count : disagree_count + 1'b1;
  assign ac_inc = (agree_count == COUNT_MAX) ? agree_count : agree_count + 1'b1;

  // debounce update
  always_comb begin
    disagree_count_next = disagree_count;
    agree_count_next    = agree_count;
    plausible_flag_next = plausible_flag;
    agrees_next         = 1'b0;
    if (plausible_flag) begin
      disagree_count_next = in_window ? '0 : dc_inc;
      if (disagree_count_next >= limit) begin
        plausible_flag_next = 1'b0;
        agrees_next         = in_window;
      end else begin
        agrees_next = 1'b1;
      end
    end else begin
      agree_count_next = in_window ? ac_inc : '0;
      if (agree_count_next >= limit) begin
        disagree_count_next = '0;
        agree_count_next    = '0;
        plausible_flag_next = 1'b1;
        agrees_next         = in_window;
      end else begin
        agrees_next = 1'b0;
      end
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      plausible_flag <= 1'b1;
      disagree_count <= '0;
      agree_count    <= '0;
      m_tvalid       <= 1'b0;
      gain           <= GAIN_RESET;
      offset         <= OFFSET_RESET;
      tolerance      <= TOL_RESET;
      limit          <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAIN:      gain      <= cfg_data[GAIN_W-1:0];
          CFG_OFFSET:    offset    <= signed'(cfg_data[OFFSET_W-1:0]);
          CFG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
          CFG_LIMIT:     limit     <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(ADC_BITS - 1)) begin
            state <= S_WIN;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WIN: begin
          if (cnt == CNT_W'(WIN_STEPS - 1)) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (commit) begin
            state          <= S_IDLE;
            plausible_flag <= plausible_flag_next;
            disagree_count <= disagree_count_next;
            agree_count    <= agree_count_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath shift registers and accumulators
  always_ff @(posedge clk) begin
    if (in_accept) begin
      low_sr <= reading_low;
      mcand  <= ACC_W'(gain);
      pred   <= -(PRED_W'(offset));
      acc_lo <= meas;
      acc_hi <= -meas;
      mlo_sr <= PERCENT_FULL - {1'b0, tolerance};
      mhi_sr <= PERCENT_FULL + {1'b0, tolerance};
    end else if (state == S_MUL) begin
      pred   <= pred_next;
      low_sr <= low_sr >> 1;
      if (cnt == CNT_W'(ADC_BITS - 1)) begin
        mcand <= ACC_W'(pred_next);
      end else begin
        mcand <= mcand <<< 1;
      end
    end else if (state == S_WIN) begin
      // top bit of 100-t carries weight -128
      if (mlo_sr[0]) begin
        acc_lo <= (cnt == CNT_W'(WIN_STEPS - 1)) ? acc_lo + mcand : acc_lo - mcand;
      end
      if (mhi_sr[0]) begin
        acc_hi <= acc_hi + mcand;
      end
      mlo_sr <= mlo_sr >> 1;
      mhi_sr <= mhi_sr >> 1;
      mcand  <= mcand <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      agrees_out    <= agrees_next;
      plausible_out <= plausible_flag_next;
    end
  end

  assign m_tdata = {6'b0, plausible_out, agrees_out};

  // checks
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid && (m_tdata[1] == plausible_flag))
    else $error("output plausibility differs from state");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && m_tvalid && !m_tready |=> (state == S_FIN))
    else $error("result finished while output register full");

  a_recover_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(plausible_flag) |-> (disagree_count == '0) && (agree_count == '0))
    else $error("counts not cleared on recovery");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) || (state == S_WIN) |-> !s_tready)
    else $error("input accepted during computation");

  a_mul_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> cnt <= CNT_W'(ADC_BITS - 1))
    else $error("multiplier step count overrun");

endmodule
